// ----- sv/sto_pkg.sv -----
// shared constants, register codes and sine table function for the tone oscillator
package sto_pkg;

  localparam int PhaseBitsDefault    = 32;
  localparam int SineAddrBitsDefault = 10;
  localparam int QueueDepth          = 2;

  localparam int StepBits   = 32;
  localparam int AmpBits    = 15;
  localparam int SampleBits = 16;
  localparam int MagBits    = 15;
  localparam int CfgIdxBits = 2;
  localparam int CfgDataBits = 32;

  localparam logic [StepBits-1:0] StepReset = 32'd42852281;
  localparam logic [AmpBits-1:0]  AmpReset  = 15'd5000;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_PHASE_STEP = 2'd0,
    REG_AMPLITUDE  = 2'd1
  } cfg_reg_e;

  // quarter-wave sine in unsigned q0.15, evaluated at elaboration only
  function automatic logic [MagBits-1:0] quarter_sine(input int unsigned v, input int qb);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] a;
    logic [63:0] s;
    logic [63:0] c [6];
    c[0] = 64'd1686629713;
    c[1] = 64'd693598672;
    c[2] = 64'd85569306;
    c[3] = 64'd5026995;
    c[4] = 64'd172272;
    c[5] = 64'd3864;
    u  = 64'(v) << (30 - qb);
    u2 = (u * u) >> 30;
    a  = c[4] - ((c[5] * u2) >> 30);
    for (int k = 3; k >= 0; k--) begin
      a = c[k] - ((a * u2) >> 30);
    end
    s = (((a * u) >> 30) + 64'd16384) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[MagBits-1:0];
  endfunction

endpackage

// ----- sv/sto_fifo.sv -----
// small register queue used between the front and back and at the result side
module sto_fifo import sto_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int AddrBits  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountBits = $clog2(Depth + 1);

  logic [Width-1:0]     mem_q [Depth];
  logic [AddrBits-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AddrBits-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CountBits-1:0] count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == CountBits'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrBits'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrBits'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- sv/sto_front.sv -----
// phase accumulator and quadrant classification of each sample tick
module sto_front import sto_pkg::*; #(
  parameter int PhaseBits    = PhaseBitsDefault,
  parameter int SineAddrBits = SineAddrBitsDefault,
  localparam int QuadBits    = SineAddrBits - 2,
  localparam int EntryBits   = QuadBits + 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  logic                 restart_i,
  input  logic                 block_end_i,
  input  logic [StepBits-1:0]  phase_step_i,
  output logic                 entry_push_o,
  output logic [EntryBits-1:0] entry_o,
  input  logic                 entry_full_i
);

  logic [PhaseBits-1:0]    phase_q, phase_d;
  logic [PhaseBits-1:0]    phase_cur;
  logic [SineAddrBits-1:0] addr;
  logic [1:0]              quad;
  logic [QuadBits:0]       pos;
  logic                    accept;

  assign full_o       = entry_full_i;
  assign accept       = push_i && !entry_full_i;
  assign entry_push_o = accept;

  always_comb begin
    phase_cur = restart_i ? '0 : phase_q;
    addr      = phase_cur[PhaseBits-1 -: SineAddrBits];
    quad      = addr[SineAddrBits-1 -: 2];
    if (quad[0]) begin
      pos = (QuadBits+1)'(1 << QuadBits) - {1'b0, addr[QuadBits-1:0]};
    end else begin
      pos = {1'b0, addr[QuadBits-1:0]};
    end
    phase_d = accept ? phase_cur + PhaseBits'(phase_step_i) : phase_q;
  end

  assign entry_o = {quad[1], pos, block_end_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

// ----- sv/sto_back.sv -----
// sine rom read, amplitude scaling and sign for each queued tick
module sto_back import sto_pkg::*; #(
  parameter int SineAddrBits = SineAddrBitsDefault,
  localparam int QuadBits    = SineAddrBits - 2,
  localparam int EntryBits   = QuadBits + 3,
  localparam int ResBits     = SampleBits + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [AmpBits-1:0]   amplitude_i,
  input  logic [EntryBits-1:0] entry_i,
  input  logic                 entry_empty_i,
  output logic                 entry_pop_o,
  output logic                 res_push_o,
  output logic [ResBits-1:0]   res_o,
  input  logic                 res_full_i
);

  localparam int RomDepth = (1 << QuadBits) + 1;
  localparam int ProdBits = AmpBits + MagBits;

  typedef logic [MagBits-1:0] rom_t [RomDepth];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < RomDepth; i++) begin
      r[i] = quarter_sine(i, QuadBits);
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic                s1_valid_q, s2_valid_q;
  logic [MagBits-1:0]  s1_mag_q;
  logic                s1_neg_q, s1_last_q;
  logic [ProdBits-1:0] s2_prod_q;
  logic                s2_neg_q, s2_last_q;
  logic                advance;
  logic [QuadBits:0]   pos;
  logic [SampleBits-1:0] scaled;

  assign advance     = !s2_valid_q || !res_full_i;
  assign entry_pop_o = advance && !entry_empty_i;
  assign res_push_o  = s2_valid_q && !res_full_i;
  assign pos         = entry_i[QuadBits+1:1];

  assign scaled = SampleBits'(s2_prod_q[ProdBits-1:MagBits]);
  assign res_o  = {s2_last_q, s2_neg_q ? SampleBits'(-scaled) : scaled};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= !entry_empty_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_mag_q  <= SineRom[pos];
      s1_neg_q  <= entry_i[EntryBits-1];
      s1_last_q <= entry_i[0];
      s2_prod_q <= ProdBits'(amplitude_i) * ProdBits'(s1_mag_q);
      s2_neg_q  <= s1_neg_q;
      s2_last_q <= s1_last_q;
    end
  end

endmodule

// ----- sv/sine_tone_oscillator_top.sv -----
// top level of the direct digital synthesis sine tone oscillator
//
//  channel   direction  transfer when            payload
//  ticks     in         push && !full            restart_i, block_end_i
//  samples   out        pop && !empty            left_sample_o, right_sample_o, last_in_block_o
//  config    in         cfg_valid_i && ready     cfg_index_i, cfg_data_i
//
// one tick is accepted per cycle while the tick queue is not full; once a tick is in the
// tick queue its sample passes the rom read, multiply and sample queue registers, and the rate
// is set by the single phase adder, rom port and multiplier each taking one tick a cycle.
// reset clears the phase, the queues and restores the register defaults.
// a stalled sample side fills the sample queue, then the back stages, then the tick queue.
module sine_tone_oscillator_top import sto_pkg::*; #(
  parameter int PhaseBits    = PhaseBitsDefault,
  parameter int SineAddrBits = SineAddrBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic                   restart_i,
  input  logic                   block_end_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [SampleBits-1:0]  left_sample_o,
  output logic [SampleBits-1:0]  right_sample_o,
  output logic                   last_in_block_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  localparam int QuadBits  = SineAddrBits - 2;
  localparam int EntryBits = QuadBits + 3;
  localparam int ResBits   = SampleBits + 1;

  logic [StepBits-1:0]  phase_step_q;
  logic [AmpBits-1:0]   amplitude_q;
  logic                 entry_push, entry_full, entry_pop, entry_empty;
  logic [EntryBits-1:0] entry_wr, entry_rd;
  logic                 res_push, res_full;
  logic [ResBits-1:0]   res_wr, res_rd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= StepReset;
      amplitude_q  <= AmpReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_PHASE_STEP) begin
        phase_step_q <= cfg_data_i[StepBits-1:0];
      end else if (cfg_index_i == REG_AMPLITUDE) begin
        amplitude_q <= cfg_data_i[AmpBits-1:0];
      end
    end
  end

  sto_front #(
    .PhaseBits   (PhaseBits),
    .SineAddrBits(SineAddrBits)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .restart_i   (restart_i),
    .block_end_i (block_end_i),
    .phase_step_i(phase_step_q),
    .entry_push_o(entry_push),
    .entry_o     (entry_wr),
    .entry_full_i(entry_full)
  );

  sto_fifo #(
    .Width(EntryBits),
    .Depth(QueueDepth)
  ) u_tick_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (entry_push),
    .data_i (entry_wr),
    .full_o (entry_full),
    .pop_i  (entry_pop),
    .data_o (entry_rd),
    .empty_o(entry_empty)
  );

  sto_back #(
    .SineAddrBits(SineAddrBits)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .amplitude_i  (amplitude_q),
    .entry_i      (entry_rd),
    .entry_empty_i(entry_empty),
    .entry_pop_o  (entry_pop),
    .res_push_o   (res_push),
    .res_o        (res_wr),
    .res_full_i   (res_full)
  );

  sto_fifo #(
    .Width(ResBits),
    .Depth(QueueDepth)
  ) u_sample_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_wr),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_rd),
    .empty_o(empty)
  );

  assign left_sample_o   = res_rd[SampleBits-1:0];
  assign right_sample_o  = res_rd[SampleBits-1:0];
  assign last_in_block_o = res_rd[SampleBits];

endmodule
